/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every enabled edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/obptm_pkg.sv */
// ----------------------------------------------------------------------------
// obptm_pkg
// Types and constants of the price-time priority matching block.
// ----------------------------------------------------------------------------
package obptm_pkg;

  localparam int MAX_ORDERS_DEF = 64;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_MATCHED = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic        side;
    logic        is_market;
    logic [31:0] limit_price;
    logic [31:0] arrival_time;
    logic [31:0] order_quantity;
    logic [31:0] last_price;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  matched_slot;
    logic [31:0] matched_price;
    logic [31:0] matched_arrival;
    logic [31:0] matched_quantity;
    logic        matched_market;
    logic [31:0] trade_quantity;
    logic [31:0] execution_price;
  } out_word_t;

  typedef struct packed {
    logic        side;
    logic        market;
    logic [31:0] price;
    logic [31:0] arrival;
    logic [31:0] quantity;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture accepted word
    logic exec;      // do load/clear, arm scan
    logic scan_rd;   // read next book slot
    logic load_out;  // move result into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_match;
    logic scan_done;
    logic out_free;
  } ctl_stat_t;

endpackage

/* rtl/core/order_book_price_time_match.sv */
// ----------------------------------------------------------------------------
// order_book_price_time_match
// Price-time priority matcher over a book of resting orders.
// ----------------------------------------------------------------------------
// Input words arrive on in_valid/in_stall/in_word; each word is a load, a
// clear or a match. Every word yields exactly one result word on
// out_valid/out_stall/out_word. One word is in work at a time: in_stall is
// high from the cycle after acceptance until the result is handed to the
// output register.
// Load and clear: the word passes the execute state, then the emit state
// loads the result into the output register and out_valid rises.
// Match: the book's single read port visits the loaded slots one per cycle,
// up to MAX_ORDERS of them, in the scan state between execute and emit.
// The book is filled from slot 0 upward, so the fill count alone marks the
// valid entries; reset empties the book and the output register at once,
// with no clearing pass.
// The result register holds its word while out_stall is high; a finished
// result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module order_book_price_time_match
  import obptm_pkg::*;
#(
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  obptm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  obptm_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  `ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.load_out, stat.out_free, "result overwrote pending word")
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "second word accepted while busy")
  `ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.load_out, out_valid, "loaded result not presented")

endmodule

/* rtl/core/obptm_ctrl.sv */
// ----------------------------------------------------------------------------
// obptm_ctrl
// Sequencer: accept, execute, scan the book, emit one result word.
// ----------------------------------------------------------------------------
module obptm_ctrl
  import obptm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.is_match ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        // last compare lands in the cycle that sees scan_done
        if (stat.scan_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/obptm_dp.sv */
// ----------------------------------------------------------------------------
// obptm_dp
// Book memory, fill count, scan compare, best-entry tracking, result register.
// ----------------------------------------------------------------------------
module obptm_dp
  import obptm_pkg::*;
#(
  parameter int MAX_ORDERS = MAX_ORDERS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  ctl_cmd_t  cmd,
  output ctl_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int AW = $clog2(MAX_ORDERS);
  localparam int CW = $clog2(MAX_ORDERS + 1);
  localparam int SW = (AW > 6) ? AW : 6;

  entry_t          book_mem [MAX_ORDERS];
  entry_t          rd_data_r;
  logic            rd_vld_r;
  logic [AW-1:0]   rd_slot_r;

  in_word_t        item_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   idx_r;
  logic            full_r;

  logic            found_r;
  logic [AW-1:0]   best_slot_r;
  entry_t          best_r;

  logic            out_valid_r;
  out_word_t       out_word_r;

  logic            book_full;
  logic            wr_en;
  entry_t          wr_entry;
  logic            crosses;
  logic            better;
  logic            take;
  logic [SW-1:0]   slot_ext;
  out_word_t       res;

  assign book_full = (count_r == CW'(MAX_ORDERS));
  assign wr_en     = cmd.exec && (item_r.kind == KIND_LOAD) && !book_full;

  always_comb begin
    wr_entry.side     = item_r.side;
    wr_entry.market   = item_r.is_market;
    wr_entry.price    = item_r.limit_price;
    wr_entry.arrival  = item_r.arrival_time;
    wr_entry.quantity = item_r.order_quantity;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      book_mem[count_r[AW-1:0]] <= wr_entry;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= book_mem[idx_r[AW-1:0]];
    end
  end

  // crossing test and price-time ranking against the running best
  always_comb begin
    if (item_r.is_market || rd_data_r.market) begin
      crosses = 1'b1;
    end else if (item_r.side == SIDE_BUY) begin
      crosses = (item_r.limit_price >= rd_data_r.price);
    end else begin
      crosses = (item_r.limit_price <= rd_data_r.price);
    end
    if (!found_r) begin
      better = 1'b1;
    end else if (rd_data_r.price != best_r.price) begin
      better = (item_r.side == SIDE_BUY) ? (rd_data_r.price < best_r.price)
                                         : (rd_data_r.price > best_r.price);
    end else begin
      better = (rd_data_r.arrival < best_r.arrival);
    end
    take = rd_vld_r && (rd_data_r.side != item_r.side) && crosses && better;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_word;
    end
    if (cmd.exec) begin
      full_r <= book_full;
    end
    if (cmd.scan_rd) begin
      rd_slot_r <= idx_r[AW-1:0];
    end
    if (take) begin
      best_r      <= rd_data_r;
      best_slot_r <= rd_slot_r;
    end
    if (cmd.load_out) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.exec) begin
        idx_r   <= '0;
        found_r <= 1'b0;
        if (item_r.kind == KIND_CLEAR) begin
          count_r <= '0;
        end else if (wr_en) begin
          count_r <= count_r + CW'(1);
        end
      end else begin
        if (cmd.scan_rd) begin
          idx_r <= idx_r + CW'(1);
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign slot_ext = SW'(best_slot_r);

  always_comb begin
    res = '0;
    case (item_r.kind)
      KIND_LOAD:  res.status = full_r ? ST_FULL : ST_OK;
      KIND_CLEAR: res.status = ST_OK;
      KIND_MATCH: begin
        if (!found_r) begin
          res.status = ST_NOMATCH;
        end else begin
          res.status           = ST_MATCHED;
          res.matched_slot     = slot_ext[5:0];
          res.matched_price    = best_r.price;
          res.matched_arrival  = best_r.arrival;
          res.matched_quantity = best_r.quantity;
          res.matched_market   = best_r.market;
          res.trade_quantity   = (item_r.order_quantity < best_r.quantity) ?
                                 item_r.order_quantity : best_r.quantity;
          if (!item_r.is_market && !best_r.market) begin
            // earlier arrival sets the price, tie goes to the resting order
            res.execution_price = (item_r.arrival_time < best_r.arrival) ?
                                  item_r.limit_price : best_r.price;
          end else if (!item_r.is_market) begin
            res.execution_price = item_r.limit_price;
          end else if (!best_r.market) begin
            res.execution_price = best_r.price;
          end else begin
            res.execution_price = item_r.last_price;
          end
        end
      end
      default: res.status = ST_NOMATCH;
    endcase
  end

  assign stat.is_match  = (item_r.kind == KIND_MATCH);
  assign stat.scan_done = (idx_r == count_r);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
